[design/key_debounce_long_press_assert.svh]
// Assertion helpers used by the checker of the key debounce block.
// Each one samples on the rising edge of clk and stays quiet while rst_n is low.
`ifndef KEY_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define KEY_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define KDLP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define KDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/kdlp_pkg.sv]
`default_nettype none

package kdlp_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned ByteW  = 8;

  localparam logic [CountW-1:0] LimitReset = 8'd100;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_HELD    = 2'd2,
    PH_LONG    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_LONG    = 2'd1,
    EV_RELEASE = 2'd2
  } key_event_t;

endpackage

`default_nettype wire

[design/key_debounce_long_press.sv]
// An accepted item that yields an event loads it into the output register, or into the skid register when stalled.
// One sample item per cycle while in_tready is high; the key state updates on each accepted item.
// in_tready drops only when the output register and the skid register both hold events.
// Reset (rst_n low, synchronous): phase idle, hold count zero, no event pending,
// long_press_samples back to 100.
`default_nettype none

module key_debounce_long_press (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration: long_press_samples
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [7:0] cfg_data,
  // input stream
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  input  wire logic [7:0] in_tdata,   // [0] key_pressed, [7:1] zero
  // result stream
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [7:0] out_tdata   // [1:0] key_event, [7:2] zero
);

  // Long-press limit register; always writable. The user must write it only when idle; the block does not enforce this.
  logic [kdlp_pkg::CountW-1:0] limit_r;

  // Debounce / hold tracking state.
  kdlp_pkg::phase_t            phase_r, phase_nxt;
  logic [kdlp_pkg::CountW-1:0] hold_count_r, hold_count_nxt;

  // Output register and skid register.
  logic                   out_valid_r, out_valid_nxt;
  kdlp_pkg::key_event_t   out_event_r, out_event_nxt;
  logic                   skid_valid_r, skid_valid_nxt;
  kdlp_pkg::key_event_t   skid_event_r, skid_event_nxt;

  // Event from the item at the input this cycle.
  logic                        ev_valid;
  kdlp_pkg::key_event_t        ev_code;
  logic                        in_acc;
  logic                        out_drain;
  logic                        down;
  logic [kdlp_pkg::CountW-1:0] limit_eff;
  logic [kdlp_pkg::CountW-1:0] count_inc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= kdlp_pkg::LimitReset;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_data;
    end
  end

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_drain = out_valid_r && out_tready;
  assign down      = in_tdata[0];

  // A limit of zero behaves as one.
  assign limit_eff = (limit_r == '0) ? {{(kdlp_pkg::CountW-1){1'b0}}, 1'b1} : limit_r;
  assign count_inc = hold_count_r + {{(kdlp_pkg::CountW-1){1'b0}}, 1'b1};

  // Per-sample state update and event decode.
  always_comb begin
    phase_nxt      = phase_r;
    hold_count_nxt = hold_count_r;
    ev_valid       = 1'b0;
    ev_code        = kdlp_pkg::EV_PRESS;
    unique case (phase_r)
      kdlp_pkg::PH_IDLE: begin
        if (down) phase_nxt = kdlp_pkg::PH_CONFIRM;
      end
      kdlp_pkg::PH_CONFIRM: begin
        // bounce: a released second sample drops back to idle silently
        if (!down) begin
          phase_nxt = kdlp_pkg::PH_IDLE;
        end else begin
          phase_nxt      = kdlp_pkg::PH_HELD;
          hold_count_nxt = '0;
          ev_valid       = 1'b1;
          ev_code        = kdlp_pkg::EV_PRESS;
        end
      end
      kdlp_pkg::PH_HELD: begin
        if (!down) begin
          phase_nxt      = kdlp_pkg::PH_IDLE;
          hold_count_nxt = '0;
          ev_valid       = 1'b1;
          ev_code        = kdlp_pkg::EV_RELEASE;
        end else begin
          hold_count_nxt = count_inc;
          if (count_inc >= limit_eff) begin
            phase_nxt = kdlp_pkg::PH_LONG;
            ev_valid  = 1'b1;
            ev_code   = kdlp_pkg::EV_LONG;
          end
        end
      end
      kdlp_pkg::PH_LONG: begin
        // hold count freezes while the key stays down after the long press
        if (!down) begin
          phase_nxt      = kdlp_pkg::PH_IDLE;
          hold_count_nxt = '0;
          ev_valid       = 1'b1;
          ev_code        = kdlp_pkg::EV_RELEASE;
        end
      end
      default: begin
        phase_nxt = kdlp_pkg::PH_IDLE;
      end
    endcase
  end

  // Output register with a one-entry skid behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_event_nxt  = out_event_r;
    skid_valid_nxt = skid_valid_r;
    skid_event_nxt = skid_event_r;
    if (skid_valid_r) begin
      // no accept possible; move the skid up once the output drains
      if (out_drain) begin
        out_valid_nxt  = 1'b1;
        out_event_nxt  = skid_event_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_drain) begin
      out_valid_nxt = in_acc && ev_valid;
      if (in_acc && ev_valid) out_event_nxt = ev_code;
    end else if (in_acc && ev_valid) begin
      // output still stalled: park the new event
      skid_valid_nxt = 1'b1;
      skid_event_nxt = ev_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= kdlp_pkg::PH_IDLE;
      hold_count_r <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r      <= phase_nxt;
        hold_count_r <= hold_count_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    out_event_r  <= out_event_nxt;
    skid_event_r <= skid_event_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(kdlp_pkg::ByteW-2){1'b0}}, out_event_r};

endmodule

`default_nettype wire

[design/kdlp_checker.sv]
`default_nettype none
`include "key_debounce_long_press_assert.svh"

module kdlp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready,
  input wire logic [7:0] cfg_data,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [7:0] in_tdata,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  // Last event taken downstream; a fresh block behaves as if a release was last.
  logic [1:0] last_ev_r;
  logic [1:0] code;
  logic       order_ok;

  assign code = out_tdata[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ev_r <= kdlp_pkg::EV_RELEASE;
    end else if (out_tvalid && out_tready) begin
      last_ev_r <= code;
    end
  end

  // press follows release, long press follows press, release follows press or long press
  assign order_ok =
    ((code == kdlp_pkg::EV_PRESS)   && (last_ev_r == kdlp_pkg::EV_RELEASE)) ||
    ((code == kdlp_pkg::EV_LONG)    && (last_ev_r == kdlp_pkg::EV_PRESS))   ||
    ((code == kdlp_pkg::EV_RELEASE) &&
     ((last_ev_r == kdlp_pkg::EV_PRESS) || (last_ev_r == kdlp_pkg::EV_LONG)));

  `KDLP_ASSERT_SAME(a_event_code, out_tvalid,
    (out_tdata[7:2] == 6'd0) && (code != 2'd3), "kdlp: bad event code")
  `KDLP_ASSERT_SAME(a_event_order, out_tvalid, order_ok, "kdlp: event out of order")
  `KDLP_ASSERT_SAME(a_stall_needs_output, !in_tready, out_tvalid,
    "kdlp: input stalled with no event pending")
  `KDLP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "kdlp: stalled event changed")

  logic unused_ok;
  assign unused_ok = &{1'b0, cfg_valid, cfg_ready, cfg_data, in_tvalid, in_tdata};

endmodule

bind key_debounce_long_press kdlp_checker u_kdlp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready),
  .cfg_data   (cfg_data),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
